/* design/smae_pkg.sv */
// Shared definitions for the stack machine ALU executor.
// Holds the command and fault codes, data widths and the default stack depth.
// No dependencies; every other design file imports this package.
package smae_pkg;

  localparam int unsigned DATA_W              = 8;
  localparam int unsigned NIBBLE_W            = 4;
  localparam int unsigned CMD_W               = 4;
  localparam int unsigned FAULT_W             = 2;
  localparam int unsigned DEPTH_OUT_W         = 5;
  localparam int unsigned STACK_DEPTH_DEFAULT = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_POP   = 4'd0,
    CMD_PUSH  = 4'd1,
    CMD_NOP   = 4'd2,
    CMD_STOP  = 4'd3,
    CMD_ADD   = 4'd4,
    CMD_SUB   = 4'd5,
    CMD_MUL   = 4'd6,
    CMD_DIV   = 4'd7,
    CMD_AND   = 4'd8,
    CMD_OR    = 4'd9,
    CMD_XOR   = 4'd10,
    CMD_NOT   = 4'd11,
    CMD_WRITE = 4'd12
  } cmd_e;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2,
    FAULT_DIV0  = 2'd3
  } fault_e;

endpackage

/* design/smae_stack_mem.sv */
// Data stack storage: one synchronous write port and one read port whose
// data is registered, so read data appears in the cycle after the address.
// Depends on smae_pkg for the data width.
module smae_stack_mem #(
  parameter int unsigned DEPTH = smae_pkg::STACK_DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [smae_pkg::DATA_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [smae_pkg::DATA_W-1:0] rdata_o
);
  import smae_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/smae_div.sv */
// Restoring divider that produces one quotient bit per cycle.
// The caller must not start it with a zero divisor. Depends on smae_pkg.
module smae_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [smae_pkg::DATA_W-1:0] dividend_i,
  input  logic [smae_pkg::DATA_W-1:0] divisor_i,
  output logic [smae_pkg::DATA_W-1:0] quotient_o,
  output logic                        done_o
);
  import smae_pkg::*;

  localparam int unsigned StepW = $clog2(DATA_W);

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] step_q;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dvs_q;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  always_comb begin
    shifted = {rem_q, quo_q[DATA_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = diff[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], 1'b1};
    end else begin
      rem_d = shifted[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepW'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

/* design/stack_machine_alu_executor_top.sv */
// Stack machine ALU executor, top level: sequencer, ALU and output register.
// Instantiates smae_stack_mem and smae_div; depends on smae_pkg.
//
// Usage: each input beat carries one decoded instruction (cmd_i plus the two
// nibbles of a push immediate). Each accepted beat yields exactly one output
// beat with the emitted character (if any), the run flag, the new top of
// stack, the new depth and a fault code. Both channels use valid/ready.
//
// The stack lives in a synchronous memory with a registered read. An
// instruction reads the top entry, then the entry below it, executes, and
// writes at most one entry back before the next instruction is taken, so
// no two accesses to the same entry ever overlap.
//
// Each instruction steps through accept, two memory reads, execute and
// write-back, and the next one is taken only after its write-back; a
// division with a nonzero divisor waits between execute and write-back for
// the bit-serial divider, which retires one quotient bit per cycle.
//
// A finished result sits in an output register, so a new instruction is
// accepted while the previous result still waits. If the receiver stalls,
// the next result is held at write-back and no further input is taken.
// Reset empties the stack, sets the machine running and drops the output valid.
// After a stop instruction every later beat is ignored and only reports.
module stack_machine_alu_executor_top #(
  parameter int unsigned STACK_DEPTH = smae_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [smae_pkg::CMD_W-1:0]       cmd_i,
  input  logic [smae_pkg::NIBBLE_W-1:0]    high_nibble_i,
  input  logic [smae_pkg::NIBBLE_W-1:0]    low_nibble_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             char_valid_o,
  output logic [smae_pkg::DATA_W-1:0]      char_out_o,
  output logic                             running_o,
  output logic [smae_pkg::DATA_W-1:0]      top_value_o,
  output logic [smae_pkg::DEPTH_OUT_W-1:0] stack_depth_o,
  output logic [smae_pkg::FAULT_W-1:0]     fault_o
);
  import smae_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD_A = 6'b000010,
    S_RD_B = 6'b000100,
    S_EXEC = 6'b001000,
    S_DIV  = 6'b010000,
    S_WB   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Architectural state held outside the memory.
  logic [CW-1:0] cnt_q;
  logic          run_q;

  // Instruction being executed and the top operand read from the stack.
  logic [CMD_W-1:0]    cmd_q;
  logic [NIBBLE_W-1:0] hi_q;
  logic [NIBBLE_W-1:0] lo_q;
  logic [DATA_W-1:0]   a_q;

  // Pending write-back, computed in the execute step; a division fills in its quotient.
  logic              we_q;
  logic [AW-1:0]     waddr_q;
  logic [DATA_W-1:0] wdata_q;
  logic [CW-1:0]     cnt_nxt_q;
  logic              run_nxt_q;
  logic [DATA_W-1:0] top_nxt_q;
  fault_e            fault_nxt_q;
  logic              cv_nxt_q;
  logic [DATA_W-1:0] ch_nxt_q;

  // Output register.
  logic              out_valid_q;
  logic              out_cv_q;
  logic [DATA_W-1:0] out_ch_q;
  logic              out_run_q;
  logic [DATA_W-1:0] out_top_q;
  logic [CW-1:0]     out_cnt_q;
  fault_e            out_fault_q;

  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;
  logic              in_fire;
  logic              wb_fire;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  logic [DATA_W-1:0] b_val;
  logic [DATA_W-1:0] imm;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0] alu_res;
  logic              has_one;
  logic              has_two;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;
  logic [31:0]       cnt_ext;

  // Execute-step results.
  logic              ex_we;
  logic [AW-1:0]     ex_waddr;
  logic [DATA_W-1:0] ex_wdata;
  logic [CW-1:0]     ex_cnt;
  logic              ex_run;
  logic [DATA_W-1:0] ex_top;
  fault_e            ex_fault;
  logic              ex_cv;
  logic [DATA_W-1:0] ex_ch;

  assign cnt_m1  = cnt_q - CW'(1);
  assign cnt_m2  = cnt_q - CW'(2);
  assign has_one = (cnt_q != '0);
  assign has_two = (cnt_q >= CW'(2));
  assign imm     = {hi_q, lo_q};
  assign b_val   = mem_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign wb_fire    = (state_q == S_WB) && (!out_valid_q || out_ready_i);
  assign mem_we     = wb_fire && we_q;

  // Top entry is read first, the one below it second.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = cnt_m1[AW-1:0];
    if (state_q == S_RD_A) begin
      mem_re = has_one;
    end else if (state_q == S_RD_B) begin
      mem_re    = has_two;
      mem_raddr = cnt_m2[AW-1:0];
    end
  end

  smae_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr_q),
    .wdata_i (wdata_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Two-operand ops take the top as the left operand.
  assign prod = a_q * b_val;

  always_comb begin
    unique case (cmd_q)
      CMD_ADD: alu_res = a_q + b_val;
      CMD_SUB: alu_res = a_q - b_val;
      CMD_MUL: alu_res = prod[DATA_W-1:0];
      CMD_AND: alu_res = a_q & b_val;
      CMD_OR:  alu_res = a_q | b_val;
      default: alu_res = a_q ^ b_val;
    endcase
  end

  assign div_start = (state_q == S_EXEC) && run_q && (cmd_q == CMD_DIV) && has_two &&
                     (b_val != '0);

  smae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_q),
    .divisor_i  (b_val),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  always_comb begin
    ex_we    = 1'b0;
    ex_waddr = cnt_m1[AW-1:0];
    ex_wdata = alu_res;
    ex_cnt   = cnt_q;
    ex_run   = run_q;
    ex_top   = has_one ? a_q : '0;
    ex_fault = FAULT_NONE;
    ex_cv    = 1'b0;
    ex_ch    = '0;
    if (run_q) begin
      unique case (cmd_q)
        CMD_POP: begin
          if (!has_one) begin
            ex_fault = FAULT_UNDER;
          end else begin
            ex_cnt = cnt_m1;
            ex_top = has_two ? b_val : '0;
          end
        end
        CMD_PUSH: begin
          if (cnt_q >= CW'(STACK_DEPTH)) begin
            ex_fault = FAULT_OVER;
          end else begin
            ex_we    = 1'b1;
            ex_waddr = cnt_q[AW-1:0];
            ex_wdata = imm;
            ex_cnt   = cnt_q + CW'(1);
            ex_top   = imm;
          end
        end
        CMD_STOP: begin
          ex_run = 1'b0;
        end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_AND, CMD_OR, CMD_XOR: begin
          if (!has_two) begin
            ex_fault = FAULT_UNDER;
          end else begin
            ex_we    = 1'b1;
            ex_waddr = cnt_m2[AW-1:0];
            ex_cnt   = cnt_m1;
            ex_top   = alu_res;
            if (cmd_q == CMD_DIV) begin
              // A zero divisor pushes zero; otherwise the divider fills in the quotient.
              ex_wdata = '0;
              ex_top   = '0;
              if (b_val == '0) begin
                ex_fault = FAULT_DIV0;
              end
            end
          end
        end
        CMD_NOT: begin
          if (!has_one) begin
            ex_fault = FAULT_UNDER;
          end else begin
            ex_we    = 1'b1;
            ex_wdata = ~a_q;
            ex_top   = ~a_q;
          end
        end
        CMD_WRITE: begin
          if (!has_one) begin
            ex_fault = FAULT_UNDER;
          end else begin
            ex_cv  = 1'b1;
            ex_ch  = a_q;
            ex_cnt = cnt_m1;
            ex_top = has_two ? b_val : '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_RD_A;
      S_RD_A: state_d = S_RD_B;
      S_RD_B: state_d = S_EXEC;
      S_EXEC: state_d = div_start ? S_DIV : S_WB;
      S_DIV:  if (div_done) state_d = S_WB;
      S_WB:   if (wb_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      run_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wb_fire) begin
        cnt_q       <= cnt_nxt_q;
        run_q       <= run_nxt_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i;
      hi_q  <= high_nibble_i;
      lo_q  <= low_nibble_i;
    end
    if (state_q == S_RD_B) begin
      a_q <= mem_rdata;
    end
    if (state_q == S_EXEC) begin
      we_q        <= ex_we;
      waddr_q     <= ex_waddr;
      wdata_q     <= ex_wdata;
      cnt_nxt_q   <= ex_cnt;
      run_nxt_q   <= ex_run;
      top_nxt_q   <= ex_top;
      fault_nxt_q <= ex_fault;
      cv_nxt_q    <= ex_cv;
      ch_nxt_q    <= ex_ch;
    end else if ((state_q == S_DIV) && div_done) begin
      wdata_q   <= div_quo;
      top_nxt_q <= div_quo;
    end
    if (wb_fire) begin
      out_cv_q    <= cv_nxt_q;
      out_ch_q    <= ch_nxt_q;
      out_run_q   <= run_nxt_q;
      out_top_q   <= top_nxt_q;
      out_cnt_q   <= cnt_nxt_q;
      out_fault_q <= fault_nxt_q;
    end
  end

  // The depth port is five bits wide; deeper stacks report it modulo 32.
  assign cnt_ext = 32'(out_cnt_q);

  assign out_valid_o   = out_valid_q;
  assign char_valid_o  = out_cv_q;
  assign char_out_o    = out_ch_q;
  assign running_o     = out_run_q;
  assign top_value_o   = out_top_q;
  assign stack_depth_o = cnt_ext[DEPTH_OUT_W-1:0];
  assign fault_o       = out_fault_q;

`ifndef SYNTHESIS
  a_cnt_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_stop_sticks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q |=> !run_q)
    else $error("machine restarted after stop");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide wait");

  a_char_no_fault : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_cv_q) |-> (out_fault_q == FAULT_NONE))
    else $error("character emitted together with a fault");

  a_write_only_at_wb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == S_WB) && run_q))
    else $error("stack written outside write-back or while stopped");
`endif

endmodule
